>>> sv/present80_pkg.sv
// ----------------------------------------------------------------------------
// present80_pkg
// shared types, constants and layer functions for the present-80 pipeline
// ----------------------------------------------------------------------------
package present80_pkg;

    localparam int BLOCK_W     = 64;
    localparam int KEY_W       = 80;
    localparam int KEY_HIGH_W  = 16;
    localparam int KEY_LOW_W   = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int RCON_W      = 5;
    localparam int ROUNDS_DEF  = 31;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1
    } cfg_reg_t;

    // what one cell hands to the next
    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] state;
        logic [KEY_W-1:0]   key;
    } cell_bus_t;

    localparam logic [3:0] SBOX [16] = '{
        4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
        4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    function automatic logic [BLOCK_W-1:0] sbox_layer(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            y[4*n +: 4] = SBOX[x[4*n +: 4]];
        end
        return y;
    endfunction

    // bit i goes to 16*i mod 63, bit 63 stays put
    function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int i = 0; i < BLOCK_W - 1; i++) begin
            y[(i * 16) % (BLOCK_W - 1)] = x[i];
        end
        y[BLOCK_W-1] = x[BLOCK_W-1];
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] round_key(input logic [KEY_W-1:0] k);
        return k[KEY_W-1 -: BLOCK_W];
    endfunction

endpackage

>>> sv/present80_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// present80_block_encrypt_top
// present-80 block encryption, fully pipelined, one block per clock
// ----------------------------------------------------------------------------
// usage
//   - key: write key_high (index 0, data bits 15:0) and key_low (index 1,
//     64 bits) through cfg_write_en / cfg_index / cfg_data while idle;
//     writes to other indexes are ignored, both registers reset to zero
//   - input: a transaction is taken at each clock edge where start is high
//     and busy is low; busy is never raised, so a new block may enter in
//     every cycle
//   - output: ciphertext is shown for exactly one cycle with done high
//   - path: a block goes from start to done through each round cell in the
//     chain in turn, then through the final key whitening register
//   - throughput: one block per cycle, each round cell carries its block
//     and its own copy of the key schedule to the next cell every cycle
//   - reset clears all valid flags in the chain and the done strobe;
//     blocks in flight are dropped
//   - the receiver cannot stall: done is a one-cycle strobe and must be
//     captured when it appears
// ----------------------------------------------------------------------------
module present80_block_encrypt_top #(
    parameter int ROUNDS = present80_pkg::ROUNDS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration port
    input  logic                                  cfg_write_en,
    input  logic [present80_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [present80_pkg::CFG_DATA_W-1:0]  cfg_data,
    // command side
    input  logic                                  start,
    output logic                                  busy,
    input  logic [present80_pkg::BLOCK_W-1:0]     plaintext,
    // result side
    output logic                                  done,
    output logic [present80_pkg::BLOCK_W-1:0]     ciphertext
);

    // key registers
    logic [present80_pkg::KEY_HIGH_W-1:0] key_high_reg;
    logic [present80_pkg::KEY_LOW_W-1:0]  key_low_reg;

    // chain of cells: entry 0 is the input, entry ROUNDS the last cell output
    present80_pkg::cell_bus_t chain [ROUNDS+1];

    // output register after the final key whitening
    logic                              done_reg;
    logic [present80_pkg::BLOCK_W-1:0] ciphertext_reg;
    logic [present80_pkg::BLOCK_W-1:0] ciphertext_next;

    // the pipeline never refuses a transaction
    assign busy = 1'b0;

    // configuration writes, decoded by register index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                present80_pkg::REG_KEY_HIGH:
                begin
                    key_high_reg <= cfg_data[present80_pkg::KEY_HIGH_W-1:0];
                end
                present80_pkg::REG_KEY_LOW:
                begin
                    key_low_reg <= cfg_data[present80_pkg::KEY_LOW_W-1:0];
                end
                default:
                begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // head of the chain takes the block straight from the ports
    assign chain[0].valid = start & ~busy;
    assign chain[0].state = plaintext;
    assign chain[0].key   = {key_high_reg, key_low_reg};

    // one cell per round, each with its own round counter
    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_round
        present80_round_cell #(
            .ROUND_NUM (g + 1)
        ) u_round_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    // final whitening with the last round key
    assign ciphertext_next = chain[ROUNDS].state ^ present80_pkg::round_key(chain[ROUNDS].key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain[ROUNDS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ciphertext_reg <= ciphertext_next;
    end

    assign done       = done_reg;
    assign ciphertext = ciphertext_reg;

    // every accepted transaction comes out after the full pipeline depth
    a_start_to_done : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(ROUNDS + 1) done)
        else $error("accepted block did not complete after the pipeline depth");

    // no result without a transaction accepted exactly that long ago
    a_done_has_start : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ROUNDS + 1))
        else $error("result strobe without a matching accepted block");

    // the strobe follows the last cell's valid flag in the next cycle
    a_done_from_chain : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(chain[ROUNDS].valid))
        else $error("result strobe not fed by the last round cell");

endmodule

>>> sv/present80_round_cell.sv
// ----------------------------------------------------------------------------
// present80_round_cell
// one cipher round plus one key schedule step, registered at the output
// ----------------------------------------------------------------------------
module present80_round_cell #(
    parameter int ROUND_NUM = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  present80_pkg::cell_bus_t cell_in,
    output present80_pkg::cell_bus_t cell_out
);

    localparam logic [present80_pkg::RCON_W-1:0] RCON = present80_pkg::RCON_W'(ROUND_NUM);

    logic                             valid_reg;
    logic [present80_pkg::BLOCK_W-1:0] state_reg;
    logic [present80_pkg::BLOCK_W-1:0] state_next;
    logic [present80_pkg::KEY_W-1:0]   key_reg;
    logic [present80_pkg::KEY_W-1:0]   key_next;
    logic [present80_pkg::KEY_W-1:0]   key_rot;

    always_comb
    begin
        state_next = present80_pkg::perm_layer(present80_pkg::sbox_layer(
            cell_in.state ^ present80_pkg::round_key(cell_in.key)));
        // rotate left by 61, s-box the top nibble, add the round counter
        key_rot  = {cell_in.key[18:0], cell_in.key[79:19]};
        key_next = key_rot;
        key_next[79:76] = present80_pkg::SBOX[key_rot[79:76]];
        key_next[19:15] = key_rot[19:15] ^ RCON;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg   <= key_next;
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.state = state_reg;
    assign cell_out.key   = key_reg;

endmodule

>>> tb/tb_present80_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// tb_present80_block_encrypt_top
// self-checking bench for the pipelined present-80 encryption block
// ----------------------------------------------------------------------------
// blocks pushed through the command port, in some phases with random idle cycles
// each accepted block encrypted by a behavioural present-80 model under the
// key currently loaded, expected ciphertext queued
// every done strobe pops the oldest expectation and compares the ciphertext
// key reloaded only once the pipeline has drained
// ----------------------------------------------------------------------------
module tb_present80_block_encrypt_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ROUNDS       = present80_pkg::ROUNDS_DEF;
    // settle time after the last result
    localparam int          DRAIN_CYCLES = ROUNDS + 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          GAP_PERCENT  = 35;

    // indexes that decode to no register, writes there must be ignored
    localparam logic [present80_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [present80_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam bit [3:0] NIBBLE_SUB [16] = '{
        4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
        4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    // ------------------------------------------------------------------------
    // scoreboard: key copy, cipher model and queue of expected ciphertexts
    // ------------------------------------------------------------------------
    class cipher_scoreboard;
        bit [present80_pkg::KEY_HIGH_W-1:0] key_high;
        bit [present80_pkg::KEY_LOW_W-1:0]  key_low;
        bit [present80_pkg::BLOCK_W-1:0]    expected_ciphertext [$];
        int unsigned                        mismatches;

        // same decode as the block: upper data bits of key_high are dropped
        function void write_key(logic [present80_pkg::CFG_INDEX_W-1:0] index,
                                logic [present80_pkg::CFG_DATA_W-1:0] data);
            if (index == present80_pkg::REG_KEY_HIGH)
                key_high = data[present80_pkg::KEY_HIGH_W-1:0];
            else if (index == present80_pkg::REG_KEY_LOW)
                key_low = data[present80_pkg::KEY_LOW_W-1:0];
        endfunction

        function bit [present80_pkg::BLOCK_W-1:0] encrypt_block(
            bit [present80_pkg::BLOCK_W-1:0] plain);
            bit [present80_pkg::KEY_W-1:0]   schedule;
            bit [present80_pkg::BLOCK_W-1:0] word;
            bit [present80_pkg::BLOCK_W-1:0] substituted;
            schedule = {key_high, key_low};
            word     = plain;
            for (int r = 1; r <= ROUNDS; r++)
            begin
                word ^= schedule[present80_pkg::KEY_W-1 -: present80_pkg::BLOCK_W];
                for (int n = 0; n < present80_pkg::BLOCK_W / 4; n++)
                    substituted[4*n +: 4] = NIBBLE_SUB[word[4*n +: 4]];
                // bit i lands on 16*i mod 63, the top bit stays
                word = '0;
                for (int i = 0; i < present80_pkg::BLOCK_W - 1; i++)
                    word[(i * 16) % (present80_pkg::BLOCK_W - 1)] = substituted[i];
                word[present80_pkg::BLOCK_W-1] = substituted[present80_pkg::BLOCK_W-1];
                // key schedule: rotate left 61, s-box top nibble, add round counter
                schedule = {schedule[18:0], schedule[present80_pkg::KEY_W-1:19]};
                schedule[79:76] = NIBBLE_SUB[schedule[79:76]];
                schedule[19:15] ^= 5'(r);
            end
            return word ^ schedule[present80_pkg::KEY_W-1 -: present80_pkg::BLOCK_W];
        endfunction

        function int pending();
            return expected_ciphertext.size();
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        function void note_block(bit [present80_pkg::BLOCK_W-1:0] plain);
            expected_ciphertext.push_back(encrypt_block(plain));
        endfunction

        task check_block(logic [present80_pkg::BLOCK_W-1:0] cipher);
            bit [present80_pkg::BLOCK_W-1:0] wanted;
            if (expected_ciphertext.size() == 0)
            begin
                report($sformatf("ciphertext %h with no block outstanding", cipher));
            end
            else
            begin
                wanted = expected_ciphertext.pop_front();
                if (cipher !== wanted)
                    report($sformatf("ciphertext %h, expected %h", cipher, wanted));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // dut wiring
    // ------------------------------------------------------------------------
    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_write_en;
    logic [present80_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [present80_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                                  start;
    logic                                  busy;
    logic [present80_pkg::BLOCK_W-1:0]     plaintext;
    logic                                  done;
    logic [present80_pkg::BLOCK_W-1:0]     ciphertext;

    cipher_scoreboard sb;
    int unsigned      cycle_count = 0;

    present80_block_encrypt_top #(
        .ROUNDS (ROUNDS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .plaintext    (plaintext),
        .done         (done),
        .ciphertext   (ciphertext)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // results cannot be held off, so every strobe is checked on the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_block(ciphertext);
    end

    // watchdog, far beyond the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers: inputs move on the falling edge, handshakes are read on the rising
    // ------------------------------------------------------------------------

    // one command transaction, optionally preceded by random idle cycles
    task automatic send_block(input logic [present80_pkg::BLOCK_W-1:0] plain,
                              input bit gaps);
        while (gaps && $urandom_range(99) < GAP_PERCENT)
        begin
            @(negedge clk);
            start        <= 1'b0;
            cfg_write_en <= 1'b0;
        end
        @(negedge clk);
        start        <= 1'b1;
        plaintext    <= plain;
        cfg_write_en <= 1'b0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_block(plain);
    endtask

    // stop sending and wait for every outstanding ciphertext
    task automatic wait_for_results();
        @(negedge clk);
        start        <= 1'b0;
        cfg_write_en <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // write enable is left high here, the next driver call drops it
    task automatic write_reg(input logic [present80_pkg::CFG_INDEX_W-1:0] index,
                             input logic [present80_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= data;
        @(posedge clk);
        sb.write_key(index, data);
    endtask

    // key changes only with an empty pipeline, every block yields a result
    task automatic load_key(input logic [present80_pkg::CFG_DATA_W-1:0] high_word,
                            input logic [present80_pkg::CFG_DATA_W-1:0] low_word);
        wait_for_results();
        write_reg(present80_pkg::REG_KEY_HIGH, high_word);
        write_reg(present80_pkg::REG_KEY_LOW, low_word);
    endtask

    function automatic logic [present80_pkg::BLOCK_W-1:0] random_plain();
        logic [present80_pkg::BLOCK_W-1:0] one_hot;
        one_hot = 64'd1 << $urandom_range(present80_pkg::BLOCK_W - 1);
        case ($urandom_range(9))
            0:       return one_hot;
            1:       return ~one_hot;
            2:       return $urandom_range(1) ? '1 : '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // pause_at < 0 means the phase never stops to drain
    task automatic run_phase(input int count, input bit gaps, input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                wait_for_results();
            send_block(random_plain(), gaps);
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = present80_pkg::REG_KEY_HIGH;
        cfg_data     = '0;
        start        = 1'b0;
        plaintext    = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset key (all zero), back-to-back field extremes and patterns
        send_block(64'h0000_0000_0000_0000, 1'b0);
        send_block(64'hffff_ffff_ffff_ffff, 1'b0);
        send_block(64'h0000_0000_0000_0001, 1'b0);
        send_block(64'h8000_0000_0000_0000, 1'b0);
        send_block(64'h5555_5555_5555_5555, 1'b0);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        send_block(64'h0123_4567_89ab_cdef, 1'b0);
        send_block(64'hfedc_ba98_7654_3210, 1'b0);

        // all-ones key
        load_key('1, '1);
        send_block(64'h0000_0000_0000_0000, 1'b1);
        send_block(64'hffff_ffff_ffff_ffff, 1'b1);
        send_block(64'h8000_0000_0000_0001, 1'b1);
        send_block(64'h7fff_ffff_ffff_fffe, 1'b1);

        // writes to undecoded indexes must leave the key untouched
        wait_for_results();
        write_reg(REG_SPARE_A, {$urandom, $urandom});
        write_reg(REG_SPARE_B, {$urandom, $urandom});
        send_block(64'h0000_0000_0000_0000, 1'b0);
        send_block(64'hffff_ffff_ffff_ffff, 1'b0);

        // junk above bit 15 of key_high is masked away
        load_key(64'hffff_ffff_ffff_0000, 64'h0);
        send_block(64'h0000_0000_0000_0000, 1'b1);
        send_block(64'hffff_ffff_ffff_ffff, 1'b1);
        send_block(64'hdead_beef_cafe_f00d, 1'b1);

        // single top and bottom key bits
        load_key(64'h0000_0000_0000_8000, 64'h0000_0000_0000_0001);
        send_block(64'h0000_0000_0000_0000, 1'b1);
        send_block(64'hffff_ffff_ffff_ffff, 1'b1);
        send_block(64'h0f0f_0f0f_0f0f_0f0f, 1'b1);

        // random traffic with idle gaps under a single key
        load_key(64'h0000_0000_0000_ffff, 64'h0);
        run_phase(120, 1'b1, -1);

        // long stretch with a block offered on every cycle
        load_key(64'h0, '1);
        run_phase(120, 1'b0, -1);

        // first random-key phase also stops midway until the pipe is empty
        for (int p = 0; p < 4; p++)
        begin
            load_key({$urandom, $urandom}, {$urandom, $urandom});
            run_phase(130, 1'b1, (p == 0) ? 60 : -1);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
